>>> hw/rtl/nearest_seed_voronoi_color_unit_macros.svh
// assertion macros for the nearest seed voronoi color unit
// used by the top level; compiled away when SYNTH is defined
`ifndef NEAREST_SEED_VORONOI_COLOR_UNIT_MACROS_SVH
`define NEAREST_SEED_VORONOI_COLOR_UNIT_MACROS_SVH
`ifndef SYNTH
`define NSV_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("nsv check failed");
`define NSV_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("nsv check failed");
`else
`define NSV_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define NSV_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

>>> hw/rtl/nsv_pkg.sv
// shared types and constants of the nearest seed voronoi color unit
// no dependencies
`default_nettype none
package nsv_pkg;
   localparam int COORD_W      = 10;
   localparam int SLOT_W       = 4;
   localparam int DIST_W       = 21;  // 2 * 1023^2 fits in 21 bits
   localparam int COLOR_W      = 32;
   localparam int PALETTE_REGS = 7;
   localparam int PALETTE_SIZE = 7;
   localparam int PAL_W        = 3;
   localparam int CSR_IDX_W    = 3;
   localparam int NUM_SEEDS_DEF = 15;

   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   localparam logic [COLOR_W-1:0] PALETTE_RESET [PALETTE_REGS] = '{
      32'hFF3449FB, 32'hFF26BBB8, 32'hFF2FBDFA, 32'hFF98A583,
      32'hFF9B86D3, 32'hFF7CC08E, 32'hFF1980FE
   };

   typedef struct packed {
      logic               mode;
      logic [SLOT_W-1:0]  seed_slot;
      logic [COORD_W-1:0] coord_x;
      logic [COORD_W-1:0] coord_y;
   } seed_item_type;
endpackage
`default_nettype wire

>>> hw/rtl/nsv_req_if.sv
// request channel interface (load / query transactions)
// depends on nsv_pkg
`default_nettype none
interface nsv_req_if;
   import nsv_pkg::*;
   logic               valid;
   logic               ready;
   logic               mode;
   logic [SLOT_W-1:0]  seed_slot;
   logic [COORD_W-1:0] coord_x;
   logic [COORD_W-1:0] coord_y;
   modport source (output valid, mode, seed_slot, coord_x, coord_y, input ready);
   modport sink (input valid, mode, seed_slot, coord_x, coord_y, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/nsv_rsp_if.sv
// response channel interface (nearest seed and color)
// depends on nsv_pkg
`default_nettype none
interface nsv_rsp_if;
   import nsv_pkg::*;
   logic               valid;
   logic               ready;
   logic [SLOT_W-1:0]  nearest_seed;
   logic [COLOR_W-1:0] pixel_color;
   modport source (output valid, nearest_seed, pixel_color, input ready);
   modport sink (input valid, nearest_seed, pixel_color, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/nsv_seed_front.sv
// input register, seed table and per-seed coordinate difference stage
// depends on nsv_pkg
`default_nettype none
module nsv_seed_front #(
   parameter int NUM_SEEDS = nsv_pkg::NUM_SEEDS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   output logic                        in_ready,
   input  wire nsv_pkg::seed_item_type in_item,
   output logic                        out_valid,
   input  wire logic                   out_ready,
   output logic [nsv_pkg::COORD_W-1:0] out_dx [NUM_SEEDS],
   output logic [nsv_pkg::COORD_W-1:0] out_dy [NUM_SEEDS]
);
   import nsv_pkg::*;

   logic          s1_valid_ff;
   seed_item_type s1_item_ff;
   logic          s2_valid_ff;
   logic          s1_adv;
   logic          s2_adv;
   logic          seed_wr;
   logic [COORD_W-1:0] seed_x_ff [NUM_SEEDS];
   logic [COORD_W-1:0] seed_y_ff [NUM_SEEDS];
   logic [COORD_W-1:0] dx_ff [NUM_SEEDS];
   logic [COORD_W-1:0] dy_ff [NUM_SEEDS];

   // stage enables, a stage moves when empty or when the next one moves
   assign s2_adv   = !s2_valid_ff || out_ready;
   assign s1_adv   = !s1_valid_ff || s2_adv;
   assign in_ready = s1_adv;

   // a load writes the table as it leaves stage 1, so later queries see it
   assign seed_wr = s1_valid_ff && (s1_item_ff.mode == MODE_LOAD) && s2_adv;

   // stage 1: registered transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         s1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s1_item_ff <= in_item;
      end
   end

   // stage 2 valid: only queries continue
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_adv) begin
         s2_valid_ff <= s1_valid_ff && (s1_item_ff.mode == MODE_QUERY);
      end
   end

   for (genvar i = 0; i < NUM_SEEDS; i++) begin : g_seed
      // seed table entry, slots beyond the table are ignored
      always_ff @(posedge clock) begin
         if (seed_wr && (32'(s1_item_ff.seed_slot) == i)) begin
            seed_x_ff[i] <= s1_item_ff.coord_x;
            seed_y_ff[i] <= s1_item_ff.coord_y;
         end
      end

      // stage 2: absolute coordinate differences
      always_ff @(posedge clock) begin
         if (s2_adv) begin
            dx_ff[i] <= (seed_x_ff[i] > s1_item_ff.coord_x) ?
                        seed_x_ff[i] - s1_item_ff.coord_x :
                        s1_item_ff.coord_x - seed_x_ff[i];
            dy_ff[i] <= (seed_y_ff[i] > s1_item_ff.coord_y) ?
                        seed_y_ff[i] - s1_item_ff.coord_y :
                        s1_item_ff.coord_y - seed_y_ff[i];
         end
      end

      assign out_dx[i] = dx_ff[i];
      assign out_dy[i] = dy_ff[i];
   end

   assign out_valid = s2_valid_ff;
endmodule
`default_nettype wire

>>> hw/rtl/nsv_dist_lanes.sv
// per-seed squared distance stage, one multiplier pair per lane
// depends on nsv_pkg
`default_nettype none
module nsv_dist_lanes #(
   parameter int NUM_SEEDS = nsv_pkg::NUM_SEEDS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   output logic                        in_ready,
   input  wire logic [nsv_pkg::COORD_W-1:0] in_dx [NUM_SEEDS],
   input  wire logic [nsv_pkg::COORD_W-1:0] in_dy [NUM_SEEDS],
   output logic                        out_valid,
   input  wire logic                   out_ready,
   output logic [nsv_pkg::DIST_W-1:0]  out_dist [NUM_SEEDS]
);
   import nsv_pkg::*;

   logic              valid_ff;
   logic              adv;
   logic [DIST_W-1:0] dist_ff [NUM_SEEDS];

   assign adv      = !valid_ff || out_ready;
   assign in_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   // dx^2 + dy^2 per lane
   for (genvar i = 0; i < NUM_SEEDS; i++) begin : g_lane
      logic [DIST_W-1:0] dx_w;
      logic [DIST_W-1:0] dy_w;
      assign dx_w = DIST_W'(in_dx[i]);
      assign dy_w = DIST_W'(in_dy[i]);
      always_ff @(posedge clock) begin
         if (adv) begin
            dist_ff[i] <= dx_w * dx_w + dy_w * dy_w;
         end
      end
      assign out_dist[i] = dist_ff[i];
   end

   assign out_valid = valid_ff;
endmodule
`default_nettype wire

>>> hw/rtl/nsv_min_tree.sv
// registered minimum tree over the seed distances, lowest index wins ties
// depends on nsv_pkg
`default_nettype none
module nsv_min_tree #(
   parameter  int NUM_SEEDS = nsv_pkg::NUM_SEEDS_DEF,
   localparam int IDX_W = (NUM_SEEDS > 1) ? $clog2(NUM_SEEDS) : 1
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   output logic                        in_ready,
   input  wire logic [nsv_pkg::DIST_W-1:0] in_dist [NUM_SEEDS],
   output logic                        out_valid,
   input  wire logic                   out_ready,
   output logic [nsv_pkg::DIST_W-1:0]  out_dist,
   output logic [IDX_W-1:0]            out_idx,
   output logic [nsv_pkg::PAL_W-1:0]   out_pal
);
   import nsv_pkg::*;

   localparam int LEVELS = (NUM_SEEDS > 1) ? $clog2(NUM_SEEDS) : 1;
   localparam int LEAVES = 1 << LEVELS;
   localparam int NODES  = LEAVES - 1;

   logic [DIST_W-1:0] leaf_dist [LEAVES];
   logic [IDX_W-1:0]  leaf_idx  [LEAVES];
   logic [PAL_W-1:0]  leaf_pal  [LEAVES];
   logic [DIST_W-1:0] dist_ff   [NODES];
   logic [IDX_W-1:0]  idx_ff    [NODES];
   logic [PAL_W-1:0]  pal_ff    [NODES];
   logic [LEVELS-1:0] valid_ff;
   logic [LEVELS-1:0] adv;

   // leaves: real seeds carry their index and palette slot, padding never wins
   for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
      if (i < NUM_SEEDS) begin : g_real
         localparam int PAL_SEL = i % PALETTE_SIZE;
         assign leaf_dist[i] = in_dist[i];
         assign leaf_idx[i]  = IDX_W'(i);
         assign leaf_pal[i]  = PAL_W'(PAL_SEL);
      end else begin : g_pad
         assign leaf_dist[i] = '1;
         assign leaf_idx[i]  = '0;
         assign leaf_pal[i]  = '0;
      end
   end

   // level valid bits and enables, level 0 is the root
   for (genvar d = 0; d < LEVELS; d++) begin : g_level
      if (d == 0) begin : g_root
         assign adv[d] = !valid_ff[d] || out_ready;
      end else begin : g_inner
         assign adv[d] = !valid_ff[d] || adv[d-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[d] <= 1'b0;
         end else if (adv[d]) begin
            if (d == LEVELS - 1) begin
               valid_ff[d] <= in_valid;
            end else begin
               valid_ff[d] <= valid_ff[(d + 1) % LEVELS];
            end
         end
      end
   end

   // compare nodes, heap order: children of k are 2k+1 and 2k+2
   for (genvar k = 0; k < NODES; k++) begin : g_node
      localparam int DEPTH = $clog2(k + 2) - 1;
      localparam int LC    = 2 * k + 1;
      localparam int RC    = 2 * k + 2;
      logic [DIST_W-1:0] l_dist;
      logic [DIST_W-1:0] r_dist;
      logic [IDX_W-1:0]  l_idx;
      logic [IDX_W-1:0]  r_idx;
      logic [PAL_W-1:0]  l_pal;
      logic [PAL_W-1:0]  r_pal;

      if (LC >= NODES) begin : g_from_leaf
         assign l_dist = leaf_dist[LC - NODES];
         assign l_idx  = leaf_idx[LC - NODES];
         assign l_pal  = leaf_pal[LC - NODES];
         assign r_dist = leaf_dist[RC - NODES];
         assign r_idx  = leaf_idx[RC - NODES];
         assign r_pal  = leaf_pal[RC - NODES];
      end else begin : g_from_node
         assign l_dist = dist_ff[LC];
         assign l_idx  = idx_ff[LC];
         assign l_pal  = pal_ff[LC];
         assign r_dist = dist_ff[RC];
         assign r_idx  = idx_ff[RC];
         assign r_pal  = pal_ff[RC];
      end

      // right side only wins when strictly closer
      always_ff @(posedge clock) begin
         if (adv[DEPTH]) begin
            if (r_dist < l_dist) begin
               dist_ff[k] <= r_dist;
               idx_ff[k]  <= r_idx;
               pal_ff[k]  <= r_pal;
            end else begin
               dist_ff[k] <= l_dist;
               idx_ff[k]  <= l_idx;
               pal_ff[k]  <= l_pal;
            end
         end
      end
   end

   assign in_ready  = adv[LEVELS-1];
   assign out_valid = valid_ff[0];
   assign out_dist  = dist_ff[0];
   assign out_idx   = idx_ff[0];
   assign out_pal   = pal_ff[0];
endmodule
`default_nettype wire

>>> hw/rtl/nearest_seed_voronoi_color_unit.sv
// nearest seed voronoi color unit, top level
// depends on nsv_pkg, nsv_req_if, nsv_rsp_if, nsv_seed_front, nsv_dist_lanes,
// nsv_min_tree and nearest_seed_voronoi_color_unit_macros.svh
//
// usage:
//   req_if carries load transactions (mode 0: seed_slot, coord_x, coord_y go
//   into the seed table) and query transactions (mode 1: pixel coord_x,
//   coord_y). A query returns one rsp_if transaction with the index of the
//   closest seed (squared euclidean distance, lowest index on ties) and the
//   palette word for index mod 7. A load returns nothing; a slot beyond the
//   table is ignored. All seeds must be loaded before they are queried.
//   csr_* writes palette register csr_index (0..6) while the block is idle;
//   the user must keep to this, the block itself does not enforce it.
// stages: input register, difference stage, square stage, one stage per level
//   of the minimum tree, output register; every stage holds one item.
// throughput: one transaction per cycle unless the receiver stalls.
// reset: clears all valid bits and restores the stock palette; the seed table
//   is left as is. When the receiver stalls, the output register holds and the
//   pipeline keeps filling its empty stages before req_if.ready drops.
`default_nettype none
`include "nearest_seed_voronoi_color_unit_macros.svh"
module nearest_seed_voronoi_color_unit #(
   parameter int NUM_SEEDS = nsv_pkg::NUM_SEEDS_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   nsv_req_if.sink                         req_if,
   nsv_rsp_if.source                       rsp_if,
   input  wire logic                       csr_write_en,
   input  wire logic [nsv_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [nsv_pkg::COLOR_W-1:0]   csr_write_data
);
   import nsv_pkg::*;

   localparam int IDX_W = (NUM_SEEDS > 1) ? $clog2(NUM_SEEDS) : 1;

   seed_item_type      req_item;
   logic               front_valid;
   logic               front_ready;
   logic [COORD_W-1:0] front_dx [NUM_SEEDS];
   logic [COORD_W-1:0] front_dy [NUM_SEEDS];
   logic               lane_valid;
   logic               lane_ready;
   logic [DIST_W-1:0]  lane_dist [NUM_SEEDS];
   logic               tree_valid;
   logic               tree_ready;
   logic [DIST_W-1:0]  tree_dist;
   logic [IDX_W-1:0]   tree_idx;
   logic [PAL_W-1:0]   tree_pal;
   logic [COLOR_W-1:0] palette_ff [PALETTE_REGS];
   logic               rsp_valid_ff;
   logic [SLOT_W-1:0]  nearest_seed_ff;
   logic [COLOR_W-1:0] pixel_color_ff;

   // palette registers, indexes beyond the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         palette_ff <= PALETTE_RESET;
      end else if (csr_write_en && (csr_index < CSR_IDX_W'(PALETTE_REGS))) begin
         palette_ff[csr_index] <= csr_write_data;
      end
   end

   // request payload into one bundle
   assign req_item.mode      = req_if.mode;
   assign req_item.seed_slot = req_if.seed_slot;
   assign req_item.coord_x   = req_if.coord_x;
   assign req_item.coord_y   = req_if.coord_y;

   nsv_seed_front #(.NUM_SEEDS(NUM_SEEDS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_if.valid),
      .in_ready  (req_if.ready),
      .in_item   (req_item),
      .out_valid (front_valid),
      .out_ready (front_ready),
      .out_dx    (front_dx),
      .out_dy    (front_dy)
   );

   nsv_dist_lanes #(.NUM_SEEDS(NUM_SEEDS)) u_lanes (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_dx     (front_dx),
      .in_dy     (front_dy),
      .out_valid (lane_valid),
      .out_ready (lane_ready),
      .out_dist  (lane_dist)
   );

   nsv_min_tree #(.NUM_SEEDS(NUM_SEEDS)) u_tree (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (lane_valid),
      .in_ready  (lane_ready),
      .in_dist   (lane_dist),
      .out_valid (tree_valid),
      .out_ready (tree_ready),
      .out_dist  (tree_dist),
      .out_idx   (tree_idx),
      .out_pal   (tree_pal)
   );

   // output register with palette lookup
   assign tree_ready = !rsp_valid_ff || rsp_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (tree_ready) begin
         rsp_valid_ff <= tree_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (tree_ready) begin
         nearest_seed_ff <= SLOT_W'(tree_idx);
         pixel_color_ff  <= palette_ff[tree_pal];
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.nearest_seed = nearest_seed_ff;
   assign rsp_if.pixel_color  = pixel_color_ff;

   // checks
   `NSV_ASSERT_SAME(a_real_seed_wins, clock, reset, tree_valid, tree_dist != '1)
   `NSV_ASSERT_NEXT(a_tree_to_output, clock, reset, tree_valid && tree_ready, rsp_if.valid)
   `NSV_ASSERT_NEXT(a_no_phantom_rsp, clock, reset, !rsp_if.valid && !tree_valid, !rsp_if.valid)
endmodule
`default_nettype wire
